// ===== rtl/mh_pkg.sv =====
// ----------------------------------------------------------------------------
// mh_pkg: shared types and constants of the MurmurHash64A stream block
// Holds the mixing constants, the item kind codes, the queued item format
// and the byte mask helper used to clear unused bytes of a short word.
// ----------------------------------------------------------------------------
package mh_pkg;

    localparam logic [63:0] MIX_M = 64'hC6A4A7935BD1E995;
    localparam int unsigned MIX_R = 47;
    localparam logic [31:0] MIX_M_LO = MIX_M[31:0];
    localparam logic [31:0] MIX_M_HI = MIX_M[63:32];

    localparam int unsigned TDATA_W = 104;
    localparam int unsigned QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_TAIL = 2'd1,
        KIND_FULL = 2'd2
    } kind_t;

    typedef struct packed {
        logic [63:0] word;
        kind_t       kind;
        logic        first;
        logic        last;
    } item_t;

    function automatic logic [63:0] byte_mask(input logic [2:0] count);
        logic [63:0] mask;
        mask = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (3'(i) < count)
            begin
                mask[8*i +: 8] = 8'hFF;
            end
        end
        return mask;
    endfunction

    function automatic logic [63:0] shift_xor(input logic [63:0] value);
        return value ^ (value >> MIX_R);
    endfunction

endpackage

// ===== rtl/murmur64a_hash_stream.sv =====
// ----------------------------------------------------------------------------
// murmur64a_hash_stream: streaming 64-bit MurmurHash64A
// Hashes byte messages that arrive as little-endian 64-bit words and gives
// one finalized hash per message.
//
// Each input beat carries one word, its byte count and the message length;
// tuser marks the first beat of a message and tlast the final one. The
// result beat carries the 64-bit hash. The user must write the seed through
// cfg_we and cfg_wdata only while the block is idle; the block itself does
// not enforce this. The seed applies to every later message. All products
// by the mixing constant share one multiplier, so the multiplier sets the
// rate: a full word runs three products, a short word one and an empty beat
// none; a first beat adds one and a last beat one more before the result beat.
// A two-entry queue lets up to two beats wait while a word is in work.
// Reset clears the seed and the running hash and empties the queue and the
// result register. When the receiver stalls, the result is held and the
// sequencer waits after the next finalization until the result is taken.
// ----------------------------------------------------------------------------
module murmur64a_hash_stream #(
    parameter int LEN_BITS = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [63:0]                cfg_wdata,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // data_word[63:0], byte_count[67:64], msg_len[99:68], zero pad[103:100]
    input  logic [mh_pkg::TDATA_W-1:0] s_axis_tdata,
    // first
    input  logic                       s_axis_tuser,
    input  logic                       s_axis_tlast,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // hash[63:0]
    output logic [63:0]                m_axis_tdata
);

    localparam int LEN_W = (LEN_BITS < 32) ? LEN_BITS : 32;
    localparam int Q_W   = $bits(mh_pkg::item_t) + LEN_W;

    logic [63:0]      seed_reg;
    logic             queue_full;
    logic             push;
    mh_pkg::item_t    front_item;
    logic [LEN_W-1:0] front_len;
    logic             q_valid;
    logic             q_pop;
    logic [Q_W-1:0]   q_data;
    mh_pkg::item_t    q_item;
    logic [LEN_W-1:0] q_len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
        end
        else if (cfg_we)
        begin
            seed_reg <= cfg_wdata;
        end
    end

    mh_front #(
        .LEN_W (LEN_W)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .queue_full    (queue_full),
        .push          (push),
        .item          (front_item),
        .len           (front_len)
    );

    mh_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({front_len, front_item}),
        .full      (queue_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .not_empty (q_valid)
    );

    assign q_item = q_data[$bits(mh_pkg::item_t)-1:0];
    assign q_len  = q_data[Q_W-1:$bits(mh_pkg::item_t)];

    mh_back #(
        .LEN_W (LEN_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .seed          (seed_reg),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_len         (q_len),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// ===== rtl/mh_queue.sv =====
// ----------------------------------------------------------------------------
// mh_queue: short queue between the front and the back
// A two-entry register queue that lets the intake and the hash sequencer
// stall independently of each other.
// ----------------------------------------------------------------------------
module mh_queue #(
    parameter int WIDTH = 100
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             not_empty
);

    localparam int PTR_W = $clog2(mh_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(mh_pkg::QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] store_reg [mh_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CNT_W'(mh_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = store_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(mh_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(mh_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/mh_front.sv =====
// ----------------------------------------------------------------------------
// mh_front: intake and classification
// Unpacks an input beat, sorts the word into full, short or empty, clears
// the unused bytes of a short word and trims the length before queueing it.
// ----------------------------------------------------------------------------
module mh_front #(
    parameter int LEN_W = 32
) (
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [mh_pkg::TDATA_W-1:0] s_axis_tdata,
    input  logic                       s_axis_tuser,
    input  logic                       s_axis_tlast,
    input  logic                       queue_full,
    output logic                       push,
    output mh_pkg::item_t              item,
    output logic [LEN_W-1:0]           len
);

    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic [31:0] msg_len;

    assign data_word     = s_axis_tdata[63:0];
    assign byte_count    = s_axis_tdata[67:64];
    assign msg_len       = s_axis_tdata[99:68];
    assign s_axis_tready = !queue_full;
    assign push          = s_axis_tvalid && !queue_full;
    assign len           = msg_len[LEN_W-1:0];

    always_comb
    begin
        item.first = s_axis_tuser;
        item.last  = s_axis_tlast;
        if (byte_count[3])
        begin
            item.kind = mh_pkg::KIND_FULL;
            item.word = data_word;
        end
        else if (byte_count[2:0] == 3'd0)
        begin
            item.kind = mh_pkg::KIND_NONE;
            item.word = data_word;
        end
        else
        begin
            item.kind = mh_pkg::KIND_TAIL;
            item.word = data_word & mh_pkg::byte_mask(byte_count[2:0]);
        end
    end

endmodule

// ===== rtl/mh_mul.sv =====
// ----------------------------------------------------------------------------
// mh_mul: multi-cycle multiplier by the mixing constant
// Forms the low 64 bits of an operand times the mixing constant from three
// 32 by 32 partial products, one per cycle, with a registered sum.
// ----------------------------------------------------------------------------
module mh_mul (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] operand,
    output logic        done,
    output logic [63:0] result
);

    logic [63:0] x_reg;
    logic [63:0] prod_reg;
    logic [63:0] acc_reg;
    logic [63:0] res_reg;
    logic [1:0]  step_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] product;
    logic [31:0] acc_hi_sum;

    assign mul_a      = (step_reg == 2'd2) ? x_reg[63:32] : x_reg[31:0];
    assign mul_b      = (step_reg == 2'd1) ? mh_pkg::MIX_M_HI : mh_pkg::MIX_M_LO;
    assign product    = 64'(mul_a) * 64'(mul_b);
    assign acc_hi_sum = acc_reg[63:32] + prod_reg[31:0];
    assign done       = done_reg;
    assign result     = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == 2'd3);
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= operand;
        end
        else if (busy_reg)
        begin
            prod_reg <= product;
            case (step_reg)
                2'd1:    acc_reg <= prod_reg;
                2'd2:    acc_reg[63:32] <= acc_hi_sum;
                2'd3:    res_reg <= {acc_hi_sum, acc_reg[31:0]};
                default: acc_reg <= acc_reg;
            endcase
        end
    end

endmodule

// ===== rtl/mh_back.sv =====
// ----------------------------------------------------------------------------
// mh_back: hash sequencer and result register
// Takes classified items from the queue, runs the seed, word mixing, tail
// and finalization steps on the shared multiplier and holds the result.
// ----------------------------------------------------------------------------
module mh_back #(
    parameter int LEN_W = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [63:0]        seed,
    input  logic               q_valid,
    input  mh_pkg::item_t      q_item,
    input  logic [LEN_W-1:0]   q_len,
    output logic               q_pop,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [63:0]        m_axis_tdata
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_INIT   = 8'b0000_0010,
        S_ABSORB = 8'b0000_0100,
        S_K1     = 8'b0000_1000,
        S_K2     = 8'b0001_0000,
        S_H      = 8'b0010_0000,
        S_FIN    = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } state_t;

    state_t        state_reg;
    state_t        state_next;
    mh_pkg::item_t item_reg;
    mh_pkg::item_t item_next;
    logic [63:0]   hash_reg;
    logic [63:0]   hash_next;
    logic [63:0]   fin_reg;
    logic [63:0]   fin_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic [63:0]   out_data_reg;
    logic [63:0]   out_data_next;
    logic          mul_start;
    logic [63:0]   mul_operand;
    logic          mul_done;
    logic [63:0]   mul_result;
    logic          out_free;

    mh_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .operand (mul_operand),
        .done    (mul_done),
        .result  (mul_result)
    );

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        hash_next      = hash_reg;
        fin_next       = fin_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        mul_start      = 1'b0;
        mul_operand    = hash_reg;
        q_pop          = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    item_next = q_item;
                    if (q_item.first)
                    begin
                        mul_start   = 1'b1;
                        mul_operand = {{(64 - LEN_W){1'b0}}, q_len};
                        state_next  = S_INIT;
                    end
                    else
                    begin
                        state_next = S_ABSORB;
                    end
                end
            end
            S_INIT:
            begin
                if (mul_done)
                begin
                    hash_next  = seed ^ mul_result;
                    state_next = S_ABSORB;
                end
            end
            S_ABSORB:
            begin
                case (item_reg.kind)
                    mh_pkg::KIND_FULL:
                    begin
                        mul_start   = 1'b1;
                        mul_operand = item_reg.word;
                        state_next  = S_K1;
                    end
                    mh_pkg::KIND_TAIL:
                    begin
                        mul_start   = 1'b1;
                        mul_operand = hash_reg ^ item_reg.word;
                        state_next  = S_H;
                    end
                    default:
                    begin
                        if (item_reg.last)
                        begin
                            mul_start   = 1'b1;
                            mul_operand = mh_pkg::shift_xor(hash_reg);
                            state_next  = S_FIN;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end
            S_K1:
            begin
                if (mul_done)
                begin
                    mul_start   = 1'b1;
                    mul_operand = mh_pkg::shift_xor(mul_result);
                    state_next  = S_K2;
                end
            end
            S_K2:
            begin
                if (mul_done)
                begin
                    mul_start   = 1'b1;
                    mul_operand = hash_reg ^ mul_result;
                    state_next  = S_H;
                end
            end
            S_H:
            begin
                if (mul_done)
                begin
                    hash_next = mul_result;
                    if (item_reg.last)
                    begin
                        mul_start   = 1'b1;
                        mul_operand = mh_pkg::shift_xor(mul_result);
                        state_next  = S_FIN;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_FIN:
            begin
                if (mul_done)
                begin
                    fin_next   = mh_pkg::shift_xor(mul_result);
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = fin_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            hash_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hash_reg      <= hash_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        fin_reg      <= fin_next;
        out_data_reg <= out_data_next;
    end

endmodule
